### hdl/lfkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfkd_pkg: shared types and constants for the lagged fibonacci decryptor
// Holds the sequencer state types, the multiply-modulo unit request and
// response types, and the fixed-point constants of the generator.
// ----------------------------------------------------------------------------
package lfkd_pkg;

    // default keystream length
    localparam int KEY_PERIOD_DEF = 1000;

    // lag table geometry
    localparam int LAG_LEN = 97;
    localparam int LAG_AW  = 7;
    localparam int FRAC_W  = 24;
    localparam logic [LAG_AW-1:0] LAG_A_INIT = 7'd96;
    localparam logic [LAG_AW-1:0] LAG_B_INIT = 7'd32;
    localparam logic [LAG_AW-1:0] LAG_LAST   = 7'd96;

    // offset sequence, fractions in units of 2^-24
    localparam logic [FRAC_W-1:0] OFFSET_INIT = 24'd362436;
    localparam logic [FRAC_W-1:0] OFFSET_STEP = 24'd7654321;
    localparam logic [FRAC_W-1:0] OFFSET_WRAP = 24'd9122892;  // modulus minus step

    // key
    localparam int KEY_LOW_W  = 64;
    localparam int KEY_HIGH_W = 32;
    localparam int KEY_W      = KEY_LOW_W + KEY_HIGH_W;

    // seeding generator
    localparam logic [7:0] SEED_LCG_MUL = 8'd53;
    localparam logic [4:0] SEED_BIT_LAST = 5'd23;
    localparam logic [1:0] SEED_INIT_LAST = 2'd3;

    // reduction steps of the shared unit
    localparam logic [1:0] MM_STEP_QUOT = 2'd0;
    localparam logic [1:0] MM_STEP_BACK = 2'd1;
    localparam logic [1:0] MM_STEP_FIX  = 2'd2;

    // configuration register indexes
    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    // request kinds on tuser
    localparam logic ACT_RESTART = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    // modulus selection of the shared unit
    typedef enum logic [2:0] {
        MM_RAW,
        MM_177,
        MM_168,
        MM_179,
        MM_169
    } mm_mod_t;

    typedef struct packed {
        logic       start;
        logic [7:0] x;
        logic [7:0] y;
        logic       z;
        mm_mod_t    sel;
    } mm_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] result;
    } mm_rsp_t;

    // lag table writes from the seeder
    typedef struct packed {
        logic              we;
        logic [LAG_AW-1:0] addr;
        logic [FRAC_W-1:0] data;
        logic              done;
    } seed_wr_t;

    typedef enum logic [3:0] {
        SD_IDLE,
        SD_INIT_LO,
        SD_INIT_LO_W,
        SD_INIT_HI,
        SD_INIT_HI_W,
        SD_P,
        SD_P_W,
        SD_M,
        SD_M_W,
        SD_D,
        SD_D_W,
        SD_B,
        SD_B_W
    } seed_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_DRAW_A,
        ST_DRAW_B,
        ST_DRAW_W,
        ST_DRAW_K,
        ST_DEC
    } main_state_t;

    function automatic logic [7:0] mod_value(input mm_mod_t sel);
        logic [7:0] v;
        case (sel)
            MM_177:  v = 8'd177;
            MM_168:  v = 8'd168;
            MM_179:  v = 8'd179;
            MM_169:  v = 8'd169;
            MM_RAW:  v = 8'd0;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // floor(2^24 / N) for the quotient estimate
    function automatic logic [16:0] recip_value(input mm_mod_t sel);
        logic [16:0] v;
        case (sel)
            MM_177:  v = 17'd94786;
            MM_168:  v = 17'd99864;
            MM_179:  v = 17'd93727;
            MM_169:  v = 17'd99273;
            MM_RAW:  v = 17'd0;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/lfkd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfkd_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lfkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/lfkd_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfkd_modmul: shared multiply-modulo unit
// Computes (x * y + z) mod N for the seeding generators: a registered
// multiply, then a reciprocal quotient estimate, a multiply-back subtract
// and one correcting subtract; raw mode returns x * y + z unreduced.
// ----------------------------------------------------------------------------
module lfkd_modmul (
    input  logic              aclk,
    input  logic              aresetn,
    input  lfkd_pkg::mm_req_t req,
    output lfkd_pkg::mm_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic        raw_reg;
    logic [1:0]  step_reg;
    logic [15:0] prod_reg;
    logic [15:0] rem_reg;
    logic [8:0]  quot_reg;
    logic [7:0]  mod_reg;
    logic [16:0] recip_reg;
    logic [15:0] prod;
    logic [7:0]  mod_sel;
    logic        start_raw;
    logic [32:0] quot_full;
    logic [16:0] back_full;

    // product plus carry-in, max 65026
    assign prod      = ({8'd0, req.x} * {8'd0, req.y}) + {15'd0, req.z};
    assign mod_sel   = lfkd_pkg::mod_value(req.sel);
    assign start_raw = (req.sel == lfkd_pkg::MM_RAW);

    // quotient estimate is exact or one low, bits 32 to 24 of the product
    assign quot_full = {17'd0, prod_reg} * {16'd0, recip_reg};
    // quotient times modulus never exceeds the product
    assign back_full = {8'd0, quot_reg} * {9'd0, mod_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= lfkd_pkg::MM_STEP_QUOT;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                step_reg <= lfkd_pkg::MM_STEP_QUOT;
                if (start_raw) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (step_reg == lfkd_pkg::MM_STEP_FIX) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    // datapath: quotient, multiply back, one correction
    always_ff @(posedge aclk) begin
        if (req.start) begin
            prod_reg  <= prod;
            rem_reg   <= prod;
            mod_reg   <= mod_sel;
            recip_reg <= lfkd_pkg::recip_value(req.sel);
            raw_reg   <= start_raw;
        end else if (busy_reg) begin
            case (step_reg)
                lfkd_pkg::MM_STEP_QUOT: quot_reg <= quot_full[32:24];
                lfkd_pkg::MM_STEP_BACK: rem_reg  <= prod_reg - back_full[15:0];
                lfkd_pkg::MM_STEP_FIX: begin
                    if (rem_reg >= {8'd0, mod_reg}) begin
                        rem_reg <= rem_reg - {8'd0, mod_reg};
                    end
                end
                default: quot_reg <= quot_reg;
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = rem_reg;

    // a reduced result is below its modulus
    a_rem_below_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && !raw_reg) |-> (rem_reg < {8'd0, mod_reg}))
        else $error("modmul result not reduced");

    // no new request while a reduction runs
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("modmul started while busy");

    // a reduction ends after its last step
    a_busy_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && step_reg == lfkd_pkg::MM_STEP_FIX) |=> (done_reg && !busy_reg))
        else $error("modmul reduction did not finish");

endmodule

### hdl/lfkd_seed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfkd_seed: lag table seeding sequencer
// Derives the four generator seeds from the key, then runs the mod-179
// multiplicative and mod-169 linear generators on the shared unit, one bit
// per step, and writes 97 entries of 24 bits each.
// ----------------------------------------------------------------------------
module lfkd_seed (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [lfkd_pkg::KEY_W-1:0]   key,
    output lfkd_pkg::mm_req_t            mm_req,
    input  lfkd_pkg::mm_rsp_t            mm_rsp,
    output lfkd_pkg::seed_wr_t           seed_wr
);

    lfkd_pkg::seed_state_t state_reg, state_next;

    logic [1:0]                      init_idx_reg;
    logic [4:0]                      bit_reg;
    logic [lfkd_pkg::LAG_AW-1:0]     entry_reg;
    logic [7:0]                      a_reg, b_reg, c_reg, d_reg, m_reg, tmp_reg;
    logic [lfkd_pkg::FRAC_W-1:0]     acc_reg;
    logic [3:0]                      byte_base;
    logic [7:0]                      kb0, kb1, kb2;
    logic [7:0]                      res8;
    logic                            last_bit;
    logic                            last_entry;
    lfkd_pkg::mm_mod_t               init_mod;

    function automatic logic [7:0] key_byte(input logic [lfkd_pkg::KEY_W-1:0] k,
                                            input logic [3:0] idx);
        return k[idx * 8 +: 8];
    endfunction

    // key bytes of the current seed: three times the seed index
    assign byte_base = {2'b00, init_idx_reg} + {1'b0, init_idx_reg, 1'b0};
    assign kb0 = key_byte(key, byte_base);
    assign kb1 = key_byte(key, byte_base + 4'd1);
    assign kb2 = key_byte(key, byte_base + 4'd2);
    assign init_mod = (init_idx_reg == lfkd_pkg::SEED_INIT_LAST) ?
                      lfkd_pkg::MM_168 : lfkd_pkg::MM_177;

    assign res8       = mm_rsp.result[7:0];
    assign last_bit   = (bit_reg == lfkd_pkg::SEED_BIT_LAST);
    assign last_entry = (entry_reg == lfkd_pkg::LAG_LAST);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lfkd_pkg::SD_IDLE: begin
                if (start) begin
                    state_next = lfkd_pkg::SD_INIT_LO;
                end
            end
            lfkd_pkg::SD_INIT_LO: state_next = lfkd_pkg::SD_INIT_LO_W;
            lfkd_pkg::SD_INIT_LO_W: begin
                if (mm_rsp.done) begin
                    state_next = lfkd_pkg::SD_INIT_HI;
                end
            end
            lfkd_pkg::SD_INIT_HI: state_next = lfkd_pkg::SD_INIT_HI_W;
            lfkd_pkg::SD_INIT_HI_W: begin
                if (mm_rsp.done) begin
                    state_next = (init_idx_reg == lfkd_pkg::SEED_INIT_LAST) ?
                                 lfkd_pkg::SD_P : lfkd_pkg::SD_INIT_LO;
                end
            end
            lfkd_pkg::SD_P: state_next = lfkd_pkg::SD_P_W;
            lfkd_pkg::SD_P_W: begin
                if (mm_rsp.done) begin
                    state_next = lfkd_pkg::SD_M;
                end
            end
            lfkd_pkg::SD_M: state_next = lfkd_pkg::SD_M_W;
            lfkd_pkg::SD_M_W: begin
                if (mm_rsp.done) begin
                    state_next = lfkd_pkg::SD_D;
                end
            end
            lfkd_pkg::SD_D: state_next = lfkd_pkg::SD_D_W;
            lfkd_pkg::SD_D_W: begin
                if (mm_rsp.done) begin
                    state_next = lfkd_pkg::SD_B;
                end
            end
            lfkd_pkg::SD_B: state_next = lfkd_pkg::SD_B_W;
            lfkd_pkg::SD_B_W: begin
                if (mm_rsp.done) begin
                    state_next = (last_bit && last_entry) ?
                                 lfkd_pkg::SD_IDLE : lfkd_pkg::SD_P;
                end
            end
            default: state_next = lfkd_pkg::SD_IDLE;
        endcase
    end

    // outputs: shared unit requests and table writes
    always_comb begin
        mm_req.start = 1'b0;
        mm_req.x     = 8'd0;
        mm_req.y     = 8'd0;
        mm_req.z     = 1'b0;
        mm_req.sel   = lfkd_pkg::MM_RAW;
        case (state_reg)
            lfkd_pkg::SD_INIT_LO: begin
                mm_req.start = 1'b1;
                mm_req.x     = kb0;
                mm_req.y     = kb1;
                mm_req.sel   = init_mod;
            end
            lfkd_pkg::SD_INIT_HI: begin
                mm_req.start = 1'b1;
                mm_req.x     = tmp_reg;
                mm_req.y     = kb2;
                mm_req.sel   = init_mod;
            end
            lfkd_pkg::SD_P: begin
                mm_req.start = 1'b1;
                mm_req.x     = a_reg;
                mm_req.y     = b_reg;
                mm_req.sel   = lfkd_pkg::MM_179;
            end
            lfkd_pkg::SD_M: begin
                mm_req.start = 1'b1;
                mm_req.x     = tmp_reg;
                mm_req.y     = c_reg;
                mm_req.sel   = lfkd_pkg::MM_179;
            end
            lfkd_pkg::SD_D: begin
                mm_req.start = 1'b1;
                mm_req.x     = lfkd_pkg::SEED_LCG_MUL;
                mm_req.y     = d_reg;
                mm_req.z     = 1'b1;
                mm_req.sel   = lfkd_pkg::MM_169;
            end
            lfkd_pkg::SD_B: begin
                mm_req.start = 1'b1;
                mm_req.x     = d_reg;
                mm_req.y     = m_reg;
                mm_req.sel   = lfkd_pkg::MM_RAW;
            end
            default: begin
                mm_req.start = 1'b0;
            end
        endcase

        // output bit is bit 5 of d * m, first bit lands in the msb
        seed_wr.we   = (state_reg == lfkd_pkg::SD_B_W) && mm_rsp.done && last_bit;
        seed_wr.addr = entry_reg;
        seed_wr.data = {acc_reg[lfkd_pkg::FRAC_W-2:0], mm_rsp.result[5]};
        seed_wr.done = seed_wr.we && last_entry;
    end

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lfkd_pkg::SD_IDLE;
            init_idx_reg <= 2'd0;
            bit_reg      <= 5'd0;
            entry_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == lfkd_pkg::SD_IDLE && start) begin
                init_idx_reg <= 2'd0;
                bit_reg      <= 5'd0;
                entry_reg    <= '0;
            end
            if (state_reg == lfkd_pkg::SD_INIT_HI_W && mm_rsp.done) begin
                init_idx_reg <= init_idx_reg + 2'd1;
            end
            if (state_reg == lfkd_pkg::SD_B_W && mm_rsp.done) begin
                if (last_bit) begin
                    bit_reg   <= 5'd0;
                    entry_reg <= entry_reg + 7'd1;
                end else begin
                    bit_reg <= bit_reg + 5'd1;
                end
            end
        end
    end

    // generator state
    always_ff @(posedge aclk) begin
        if (mm_rsp.done) begin
            case (state_reg)
                lfkd_pkg::SD_INIT_LO_W: tmp_reg <= res8;
                lfkd_pkg::SD_INIT_HI_W: begin
                    case (init_idx_reg)
                        2'd0:    a_reg <= res8 + 8'd1;
                        2'd1:    b_reg <= res8 + 8'd1;
                        2'd2:    c_reg <= res8 + 8'd1;
                        default: d_reg <= res8;
                    endcase
                end
                lfkd_pkg::SD_P_W: tmp_reg <= res8;
                lfkd_pkg::SD_M_W: m_reg <= res8;
                lfkd_pkg::SD_D_W: d_reg <= res8;
                lfkd_pkg::SD_B_W: begin
                    acc_reg <= {acc_reg[lfkd_pkg::FRAC_W-2:0], mm_rsp.result[5]};
                    a_reg   <= b_reg;
                    b_reg   <= c_reg;
                    c_reg   <= m_reg;
                end
                default: begin
                    tmp_reg <= tmp_reg;
                end
            endcase
        end
    end

    // a new seeding starts only from idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && state_reg != lfkd_pkg::SD_IDLE) |-> 1'b0)
        else $error("seeding restarted while running");

    // every table write goes inside the table
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seed_wr.we |-> (entry_reg <= lfkd_pkg::LAG_LAST))
        else $error("seed write out of range");

    // the last write returns the sequencer to idle
    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        seed_wr.done |=> (state_reg == lfkd_pkg::SD_IDLE))
        else $error("seeder did not stop after last entry");

endmodule

### hdl/lagged_fibonacci_keystream_decrypt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_fibonacci_keystream_decrypt_unit: lagged fibonacci keystream decryptor
// Seeds a subtractive lagged fibonacci generator from a 12-byte key, stores
// a keystream and subtracts it from incoming bytes modulo 256.
// ----------------------------------------------------------------------------
// A request with tuser low restarts the block: the 97-entry lag table is
// seeded from the key registers and KEY_PERIOD keystream bytes are drawn
// and stored; it returns no result. Seeding runs on the shared
// multiply-modulo unit (key setup, then three modular steps and one raw
// product per seed bit, 2328 seed bits), and the draws share the single
// read port of the lag table. s_tready stays low meanwhile. A request
// with tuser high decrypts the byte in tdata and returns one result
// through the registered read of the keystream memory, held back while
// the previous result waits on m_tready.
// Before the first restart the keystream reads as zero, so bytes pass
// unchanged. The key registers take effect at the next restart.
module lagged_fibonacci_keystream_decrypt_unit #(
    parameter int KEY_PERIOD = lfkd_pkg::KEY_PERIOD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] cipher_byte
    input  logic        s_tuser,   // [0] action
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] plain_byte
);

    localparam int KS_AW = (KEY_PERIOD > 1) ? $clog2(KEY_PERIOD) : 1;
    localparam logic [KS_AW-1:0] KS_LAST = KS_AW'(KEY_PERIOD - 1);

    lfkd_pkg::main_state_t state_reg, state_next;

    logic [lfkd_pkg::KEY_LOW_W-1:0]  key_low_reg;
    logic [lfkd_pkg::KEY_HIGH_W-1:0] key_high_reg;

    logic [lfkd_pkg::LAG_AW-1:0] ia_reg, ib_reg;
    logic [lfkd_pkg::FRAC_W-1:0] off_reg;
    logic [lfkd_pkg::FRAC_W-1:0] ra_reg;
    logic [lfkd_pkg::FRAC_W-1:0] v_reg;
    logic [KS_AW-1:0]            draw_cnt_reg;
    logic [KS_AW-1:0]            pos_reg;
    logic                        ks_valid_reg;
    logic [7:0]                  cipher_reg;
    logic                        m_valid_reg;
    logic [7:0]                  m_data_reg;

    logic                        s_accept;
    logic                        restart;
    logic                        out_free;
    logic                        last_draw;

    lfkd_pkg::mm_req_t  mm_req;
    lfkd_pkg::mm_rsp_t  mm_rsp;
    lfkd_pkg::seed_wr_t seed_wr;

    logic                        tbl_we;
    logic [lfkd_pkg::LAG_AW-1:0] tbl_waddr, tbl_raddr;
    logic [lfkd_pkg::FRAC_W-1:0] tbl_wdata, tbl_rdata;
    logic [lfkd_pkg::FRAC_W-1:0] draw_v;
    logic [lfkd_pkg::FRAC_W-1:0] draw_out;
    logic                        ks_we;
    logic [7:0]                  ks_rdata;
    logic [7:0]                  ks_byte;

    assign s_tready  = (state_reg == lfkd_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign restart   = s_accept && (s_tuser == lfkd_pkg::ACT_RESTART);
    assign out_free  = !m_valid_reg || m_tready;
    assign last_draw = (draw_cnt_reg == KS_LAST);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == lfkd_pkg::CFG_KEY_LOW) begin
                key_low_reg <= cfg_wdata;
            end else begin
                key_high_reg <= cfg_wdata[lfkd_pkg::KEY_HIGH_W-1:0];
            end
        end
    end

    // seeding sequencer and its shared arithmetic unit
    lfkd_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    lfkd_seed u_seed (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (restart),
        .key     ({key_high_reg, key_low_reg}),
        .mm_req  (mm_req),
        .mm_rsp  (mm_rsp),
        .seed_wr (seed_wr)
    );

    // lag table: seeder writes while seeding, draws afterwards
    assign draw_v    = ra_reg - tbl_rdata;
    assign tbl_we    = seed_wr.we || (state_reg == lfkd_pkg::ST_DRAW_W);
    assign tbl_waddr = (state_reg == lfkd_pkg::ST_SEED) ? seed_wr.addr : ia_reg;
    assign tbl_wdata = (state_reg == lfkd_pkg::ST_SEED) ? seed_wr.data : draw_v;
    assign tbl_raddr = (state_reg == lfkd_pkg::ST_DRAW_B) ? ib_reg : ia_reg;

    lfkd_ram #(
        .WIDTH (lfkd_pkg::FRAC_W),
        .DEPTH (lfkd_pkg::LAG_LEN)
    ) u_lag_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // keystream: top byte of draw minus offset
    assign draw_out = v_reg - off_reg;
    assign ks_we    = (state_reg == lfkd_pkg::ST_DRAW_K);
    assign ks_byte  = ks_valid_reg ? ks_rdata : 8'd0;

    lfkd_ram #(
        .WIDTH (8),
        .DEPTH (KEY_PERIOD)
    ) u_ks_ram (
        .aclk  (aclk),
        .we    (ks_we),
        .waddr (draw_cnt_reg),
        .wdata (draw_out[lfkd_pkg::FRAC_W-1 -: 8]),
        .raddr (pos_reg),
        .rdata (ks_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lfkd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == lfkd_pkg::ACT_RESTART) ?
                                 lfkd_pkg::ST_SEED : lfkd_pkg::ST_DEC;
                end
            end
            lfkd_pkg::ST_SEED: begin
                if (seed_wr.done) begin
                    state_next = lfkd_pkg::ST_DRAW_A;
                end
            end
            lfkd_pkg::ST_DRAW_A: state_next = lfkd_pkg::ST_DRAW_B;
            lfkd_pkg::ST_DRAW_B: state_next = lfkd_pkg::ST_DRAW_W;
            lfkd_pkg::ST_DRAW_W: state_next = lfkd_pkg::ST_DRAW_K;
            lfkd_pkg::ST_DRAW_K: begin
                state_next = last_draw ? lfkd_pkg::ST_IDLE : lfkd_pkg::ST_DRAW_A;
            end
            lfkd_pkg::ST_DEC: begin
                if (out_free) begin
                    state_next = lfkd_pkg::ST_IDLE;
                end
            end
            default: state_next = lfkd_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lfkd_pkg::ST_IDLE;
            ia_reg       <= lfkd_pkg::LAG_A_INIT;
            ib_reg       <= lfkd_pkg::LAG_B_INIT;
            off_reg      <= lfkd_pkg::OFFSET_INIT;
            draw_cnt_reg <= '0;
            pos_reg      <= '0;
            ks_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            // restart reloads the generator indexes and offset
            if (restart) begin
                ia_reg       <= lfkd_pkg::LAG_A_INIT;
                ib_reg       <= lfkd_pkg::LAG_B_INIT;
                off_reg      <= lfkd_pkg::OFFSET_INIT;
                draw_cnt_reg <= '0;
            end

            // offset steps down, wrapping modulo 16777213
            if (state_reg == lfkd_pkg::ST_DRAW_A) begin
                if (off_reg < lfkd_pkg::OFFSET_STEP) begin
                    off_reg <= off_reg + lfkd_pkg::OFFSET_WRAP;
                end else begin
                    off_reg <= off_reg - lfkd_pkg::OFFSET_STEP;
                end
            end

            // lag indexes walk down with wrap
            if (state_reg == lfkd_pkg::ST_DRAW_W) begin
                ia_reg <= (ia_reg == '0) ? lfkd_pkg::LAG_LAST : ia_reg - 7'd1;
                ib_reg <= (ib_reg == '0) ? lfkd_pkg::LAG_LAST : ib_reg - 7'd1;
            end

            // keystream fill count
            if (state_reg == lfkd_pkg::ST_DRAW_K) begin
                if (last_draw) begin
                    ks_valid_reg <= 1'b1;
                    pos_reg      <= '0;
                end else begin
                    draw_cnt_reg <= draw_cnt_reg + 1'b1;
                end
            end

            // output register and stream position
            if (state_reg == lfkd_pkg::ST_DEC && out_free) begin
                m_valid_reg <= 1'b1;
                pos_reg     <= (pos_reg == KS_LAST) ? '0 : pos_reg + 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cipher_reg <= s_tdata;
        end
        if (state_reg == lfkd_pkg::ST_DRAW_B) begin
            ra_reg <= tbl_rdata;
        end
        if (state_reg == lfkd_pkg::ST_DRAW_W) begin
            v_reg <= draw_v;
        end
        if (state_reg == lfkd_pkg::ST_DEC && out_free) begin
            m_data_reg <= cipher_reg - ks_byte;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a restart closes the request channel on the next cycle
    a_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == lfkd_pkg::ACT_RESTART) |=> !s_tready)
        else $error("request taken during restart");

    // stream position stays inside the keystream
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= KS_LAST)
        else $error("stream position out of range");

    // lag indexes stay inside the table
    a_lag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ia_reg <= lfkd_pkg::LAG_LAST) && (ib_reg <= lfkd_pkg::LAG_LAST))
        else $error("lag index out of range");

    // a decrypt with a free output slot presents a result next cycle
    a_dec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lfkd_pkg::ST_DEC && out_free) |=>
        (m_valid_reg && state_reg == lfkd_pkg::ST_IDLE))
        else $error("decrypt result not delivered");

endmodule

### tb/sv/tb_lagged_fibonacci_keystream_decrypt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lagged_fibonacci_keystream_decrypt_unit: self-checking decryptor bench
// Drives key writes, restart and decrypt requests with random gaps and
// result-side backpressure. A scoreboard rebuilds the lag table and the
// keystream on every restart and checks each plain byte in order.
// ----------------------------------------------------------------------------
module tb_lagged_fibonacci_keystream_decrypt_unit;
    import lfkd_pkg::*;

    // seeding generator moduli
    localparam int unsigned SEED_ABC_MOD = 177;
    localparam int unsigned SEED_D_MOD   = 168;
    localparam int unsigned MUL_MOD      = 179;
    localparam int unsigned LCG_MOD      = 169;
    localparam int unsigned LCG_MUL      = 53;

    // run timing
    localparam int RESTART_CYCLES = 39616 + 4 * KEY_PERIOD_DEF + 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LIMIT_CYCLES   = 3_000_000;
    localparam int MAX_SHOWN      = 10;

    // tracks the keystream and the plain bytes still owed by the block
    class plain_byte_scoreboard;
        logic [63:0] key_lo;
        logic [31:0] key_hi;
        logic [23:0] lag_frac [LAG_LEN];
        int unsigned lag_a;
        int unsigned lag_b;
        logic [23:0] offset;
        logic [7:0]  stream [KEY_PERIOD_DEF];
        int unsigned position;
        logic [7:0]  plain_q [$];
        bit          last_restart;
        int          errors;
        int          checked;
        int          restarts;
        int          decrypts;
        int          wraps;

        function new();
            key_lo = '0;
            key_hi = '0;
            foreach (lag_frac[i]) lag_frac[i] = '0;
            foreach (stream[i]) stream[i] = '0;
            lag_a = LAG_A_INIT;
            lag_b = LAG_B_INIT;
            offset = OFFSET_INIT;
            position = 0;
            last_restart = 0;
            errors = 0;
            checked = 0;
            restarts = 0;
            decrypts = 0;
            wraps = 0;
        endfunction

        function void load_key(logic [63:0] lo, logic [31:0] hi);
            key_lo = lo;
            key_hi = hi;
        endfunction

        function int unsigned key_byte(int k);
            if (k < 8) begin
                return key_lo[8*k +: 8];
            end
            return key_hi[8*(k-8) +: 8];
        endfunction

        function int unsigned key_triple(int k);
            return key_byte(k) * key_byte(k + 1) * key_byte(k + 2);
        endfunction

        // one step of the subtractive lag generator, top byte of the mix
        function logic [7:0] draw_byte();
            int unsigned ia;
            int unsigned ib;
            logic [23:0] v;
            logic [23:0] mix;
            ia = lag_a % LAG_LEN;
            ib = lag_b % LAG_LEN;
            v = lag_frac[ia] - lag_frac[ib];
            lag_frac[ia] = v;
            lag_a = (ia == 0) ? LAG_LEN - 1 : ia - 1;
            lag_b = (ib == 0) ? LAG_LEN - 1 : ib - 1;
            if (offset < OFFSET_STEP) begin
                offset = offset + OFFSET_WRAP;
            end else begin
                offset = offset - OFFSET_STEP;
            end
            mix = v - offset;
            return mix[23:16];
        endfunction

        // rebuild the lag table from the key, then the whole keystream
        function void reseed_keystream();
            int unsigned a;
            int unsigned b;
            int unsigned c;
            int unsigned d;
            int unsigned m;
            int unsigned acc;
            int e;
            int n;
            lag_a = LAG_A_INIT;
            lag_b = LAG_B_INIT;
            a = 1 + key_triple(0) % SEED_ABC_MOD;
            b = 1 + key_triple(3) % SEED_ABC_MOD;
            c = 1 + key_triple(6) % SEED_ABC_MOD;
            d = key_triple(9) % SEED_D_MOD;
            for (e = 0; e < LAG_LEN; e++) begin
                acc = 0;
                for (n = 0; n < 24; n++) begin
                    m = (((a * b) % MUL_MOD) * c) % MUL_MOD;
                    a = b;
                    b = c;
                    c = m;
                    d = (LCG_MUL * d + 1) % LCG_MOD;
                    if ((d * m) % 64 >= 32) acc = acc | (32'd1 << (23 - n));
                end
                lag_frac[e] = acc[23:0];
            end
            offset = OFFSET_INIT;
            for (e = 0; e < KEY_PERIOD_DEF; e++) stream[e] = draw_byte();
            position = 0;
        endfunction

        function void note_request(logic act, logic [7:0] cipher);
            logic [7:0] plain;
            if (act == ACT_RESTART) begin
                reseed_keystream();
                restarts++;
                last_restart = 1;
            end else begin
                plain = cipher - stream[position];
                plain_q.push_back(plain);
                position++;
                if (position >= KEY_PERIOD_DEF) begin
                    position = 0;
                    wraps++;
                end
                decrypts++;
                last_restart = 0;
            end
        endfunction

        function void check_plain(logic [7:0] got);
            logic [7:0] want;
            if (plain_q.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected plain byte %02h, none pending", got);
            end else begin
                want = plain_q.pop_front();
                checked++;
                if (got !== want) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("plain byte mismatch: expected %02h, got %02h", want, got);
                end
            end
        endfunction

        function int pending();
            return plain_q.size();
        endfunction

        function void report_leftover();
            if (plain_q.size() != 0) begin
                errors += plain_q.size();
                $display("%0d plain bytes never arrived", plain_q.size());
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_KEY_LOW;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] cipher_byte
    logic        s_tuser   = ACT_DECRYPT;   // [0] action
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;   // [7:0] plain_byte

    plain_byte_scoreboard sb;
    int idle_pct = 35;
    int cycle_count = 0;

    lagged_fibonacci_keystream_decrypt_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 8 ns clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // result-side backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // watch both channels: results first, then the accepted request
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_plain(m_tdata);
            if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one request, with random idle cycles ahead of it
    task automatic send_request(input logic act, input logic [7:0] data);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending and wait until the block has nothing left to do
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.last_restart) repeat (RESTART_CYCLES) @(posedge aclk);
    endtask

    // both key registers, back to back
    task automatic set_key(input logic [63:0] lo, input logic [31:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_KEY_LOW;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= CFG_KEY_HIGH;
        cfg_wdata <= {32'd0, hi};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.load_key(lo, hi);
    endtask

    initial begin
        int phase;
        int n;
        int burst;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // before any restart the keystream is zero
        send_request(ACT_DECRYPT, 8'h00);
        send_request(ACT_DECRYPT, 8'hFF);
        send_request(ACT_DECRYPT, 8'hA5);
        send_request(ACT_DECRYPT, 8'h5A);
        drain_results();

        // all-zero key
        set_key('0, '0);
        send_request(ACT_RESTART, 8'h00);
        send_request(ACT_DECRYPT, 8'h00);
        send_request(ACT_DECRYPT, 8'hFF);
        send_request(ACT_DECRYPT, 8'h80);
        drain_results();

        // all-ones key
        set_key('1, '1);
        send_request(ACT_RESTART, 8'hFF);
        send_request(ACT_DECRYPT, 8'hFF);
        send_request(ACT_DECRYPT, 8'h00);
        send_request(ACT_DECRYPT, 8'h01);
        send_request(ACT_DECRYPT, 8'h7F);
        drain_results();

        // new key without a restart keeps the old keystream running
        set_key({$urandom, $urandom}, $urandom);
        send_request(ACT_DECRYPT, 8'h3C);
        send_request(ACT_DECRYPT, 8'hC3);
        send_request(ACT_DECRYPT, 8'h10);
        send_request(ACT_RESTART, 8'h55);
        send_request(ACT_DECRYPT, 8'hEF);
        send_request(ACT_DECRYPT, 8'h02);

        // random phases: new key, restart, a burst of random bytes
        for (phase = 0; phase < 4; phase++) begin
            drain_results();
            if (phase == 1) begin
                set_key('1, $urandom);
            end else if (phase == 2) begin
                set_key({$urandom, $urandom}, '0);
            end else begin
                set_key({$urandom, $urandom}, $urandom);
            end
            send_request(ACT_RESTART, 8'($urandom_range(255)));
            // first burst runs past the keystream end
            burst = (phase == 0) ? 1150 : 230;
            for (n = 0; n < burst; n++) begin
                if (phase == 0) idle_pct = (n < 450) ? 0 : 35;
                if (phase == 2 && n == burst / 2)
                    send_request(ACT_RESTART, 8'($urandom_range(255)));
                send_request(ACT_DECRYPT, 8'($urandom_range(255)));
            end
        end

        drain_results();
        sb.report_leftover();
        $display("covered %0d decrypt requests across %0d restarts, %0d results checked",
                 sb.decrypts, sb.restarts, sb.checked);
        $display("keystream wrapped %0d times, %0d errors", sb.wraps, sb.errors);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
